// File: hdl/slwm_pkg.sv
`default_nettype none

package slwm_pkg;

    localparam int PATTERN_MAX_DEF = 32;

    localparam logic [7:0] PAD_BYTE = 8'h20;
    localparam logic [7:0] ANY_RUN  = 8'h25;
    localparam logic [7:0] ANY_ONE  = 8'h5F;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_SUBJECT = 1'b1;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // Control shared by every cell of the position chain for one subject item.
    typedef struct packed {
        logic       start;
        logic       has;
        logic       upd;
        logic       pad;
        logic [7:0] ch;
    } slwm_ctl_t;

endpackage

`default_nettype wire

// File: hdl/slwm_cell.sv
`default_nettype none

module slwm_cell (
    input  wire               clk,
    input  wire               rst_n,
    input  slwm_pkg::slwm_ctl_t ctl,
    input  wire               home,
    input  wire               wr_en,
    input  wire               valid,
    input  wire               at_end,
    input  wire               carry_in,
    input  wire               adv_in,
    input  wire               tail_in,
    output logic              carry_out,
    output logic              adv_out,
    output logic              tail_out,
    output logic              hit
);
    import slwm_pkg::*;

    logic [7:0] byte_reg;
    logic       act_reg;
    logic       act_next;
    logic       cur;
    logic       closed;
    logic       pct;
    logic       pad_loop;
    logic       nxt;
    logic       vset;
    logic       tail_ok;

    always_comb
    begin
        cur       = ctl.start ? home : act_reg;
        closed    = cur | carry_in;
        pct       = valid & (byte_reg == ANY_RUN);
        carry_out = closed & pct;
        adv_out   = closed & valid & ~pct &
                    ((byte_reg == ANY_ONE) || (byte_reg == ctl.ch));
        pad_loop  = closed & at_end & ctl.pad & (ctl.ch == PAD_BYTE);
        nxt       = carry_out | adv_in | pad_loop;
        vset      = ctl.has ? nxt : cur;
        tail_ok   = (byte_reg == ANY_RUN) ||
                    (ctl.pad && ((byte_reg == ANY_ONE) || (byte_reg == PAD_BYTE)));
        tail_out  = ~valid | (tail_ok & tail_in);
        hit       = vset & tail_out;
        act_next  = ctl.upd ? vset : act_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byte_reg <= ctl.ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/sql_like_wildcard_matcher.sv
// SQL LIKE pattern matcher.
// The input stream carries one byte per item: tuser selects a pattern byte (0)
// or a subject byte (1), tdata holds the byte and a has-char flag, and tlast
// closes a pattern or a subject. A subject item with tlast yields one result
// item holding the match verdict and the pattern-too-long flag.
// Each stored pattern byte lives in its own cell together with its bit of the
// live-position set; all cells update together, so one item is taken every
// cycle unless the output stalls, a rate set by the single update of the cell
// row. A result is registered and shows in the cycle after the closing subject
// item is accepted; the critical path is the ripple through runs of '%'.
// The output register holds a result until it is taken; while it is full and
// the receiver stalls, the input is not ready.
// Reset empties the pattern, clears the overflow flag and pad mode, leaves no
// subject open. The user writes the pad mode register through cfg_wr_en and
// cfg_wr_data only while no item is in flight; the block does not enforce it.
`default_nettype none

module sql_like_wildcard_matcher #(
    parameter int PATTERN_MAX = slwm_pkg::PATTERN_MAX_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_wr_en,
    input  wire                              cfg_wr_data,   // pad_mode
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [slwm_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // char_value[7:0], has_char[8]
    input  wire                              s_axis_tuser,  // kind
    input  wire                              s_axis_tlast,  // last
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [slwm_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // matched[0], pattern_too_long[1]
);
    import slwm_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);

    logic          pad_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          closed_reg;
    logic          closed_next;
    logic          open_reg;
    logic          open_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          matched_reg;
    logic          matched_next;
    logic          too_long_reg;
    logic          too_long_next;

    logic          accept;
    logic          pat_acc;
    logic          sub_acc;
    logic          has;
    logic          lst;
    logic [7:0]    ch;
    logic [LW-1:0] len_eff;
    logic          full;
    logic          any_hit;

    slwm_ctl_t     ctl;

    logic [PATTERN_MAX+1:0] carry;
    logic [PATTERN_MAX+1:0] adv;
    logic [PATTERN_MAX+1:0] tail;
    logic [PATTERN_MAX:0]   hit;

    assign ch  = s_axis_tdata[7:0];
    assign has = s_axis_tdata[8];
    assign lst = s_axis_tlast;

    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign accept  = s_axis_tvalid & s_axis_tready;
    assign pat_acc = accept & (s_axis_tuser == KIND_PATTERN);
    assign sub_acc = accept & (s_axis_tuser == KIND_SUBJECT) & (has | lst);

    assign len_eff = closed_reg ? '0 : len_reg;
    assign full    = (len_eff == LW'(PATTERN_MAX));

    always_comb
    begin
        ctl.start = ~open_reg;
        ctl.has   = has;
        ctl.upd   = sub_acc;
        ctl.pad   = pad_reg;
        ctl.ch    = ch;
    end

    assign carry[0]             = 1'b0;
    assign adv[0]               = 1'b0;
    assign tail[PATTERN_MAX+1]  = 1'b1;

    genvar p;
    generate
        for (p = 0; p <= PATTERN_MAX; p++)
        begin : g_cell
            logic wr_en;
            if (p < PATTERN_MAX)
            begin : g_wr
                assign wr_en = pat_acc & has & ~full & (len_eff == LW'(p));
            end
            else
            begin : g_nowr
                assign wr_en = 1'b0;
            end

            slwm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .home      ((p == 0) ? 1'b1 : 1'b0),
                .wr_en     (wr_en),
                .valid     (LW'(p) < len_reg),
                .at_end    (len_reg == LW'(p)),
                .carry_in  (carry[p]),
                .adv_in    (adv[p]),
                .tail_in   (tail[p+1]),
                .carry_out (carry[p+1]),
                .adv_out   (adv[p+1]),
                .tail_out  (tail[p]),
                .hit       (hit[p])
            );
        end
    endgenerate

    assign any_hit = |hit;

    always_comb
    begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        closed_next    = closed_reg;
        open_next      = open_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        matched_next   = matched_reg;
        too_long_next  = too_long_reg;

        if (pat_acc)
        begin
            open_next = 1'b0;
            len_next  = len_eff;
            ovf_next  = closed_reg ? 1'b0 : ovf_reg;
            if (has)
            begin
                if (!full)
                begin
                    len_next = len_eff + LW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            closed_next = lst;
        end
        else if (sub_acc)
        begin
            open_next = ~lst;
            if (lst)
            begin
                out_valid_next = 1'b1;
                matched_next   = ~ovf_reg & any_hit;
                too_long_next  = ovf_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg       <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            closed_reg    <= 1'b1;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pad_reg <= cfg_wr_data;
            end
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            closed_reg    <= closed_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg  <= matched_next;
        too_long_reg <= too_long_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 2){1'b0}}, too_long_reg, matched_reg};

endmodule

`default_nettype wire
